FILE: design/double_float_adder_truncating_unit_macros.svh
// Assertion macros for the truncating binary64 adder
`ifndef DOUBLE_FLOAT_ADDER_TRUNCATING_UNIT_MACROS_SVH
`define DOUBLE_FLOAT_ADDER_TRUNCATING_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define DFA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define DFA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: design/dfa_pkg.sv
// Shared constants and types for the truncating binary64 adder
package dfa_pkg;
    localparam int unsigned FracWidth = 52;
    localparam int unsigned MantWidth = 53;
    localparam int unsigned ExpWidth  = 11;
    localparam int unsigned SignPos   = 63;
    localparam int unsigned WordWidth = 64;
    localparam logic [ExpWidth-1:0] ExpMax = 11'd2046;

    // Item carried on the output channel
    typedef struct packed {
        logic [WordWidth-1:0] sum_bits;
        logic                 range_error;
    } t_result;
endpackage

FILE: design/dfa_if.sv
// Valid/ready channel interfaces for operands and results
interface dfa_in_if;
    logic                                valid;
    logic                                ready;
    logic [dfa_pkg::WordWidth-1:0]       operand_a;
    logic [dfa_pkg::WordWidth-1:0]       operand_b;
    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface dfa_out_if;
    logic                                valid;
    logic                                ready;
    logic [dfa_pkg::WordWidth-1:0]       sum_bits;
    logic                                range_error;
    modport source (output valid, output sum_bits, output range_error, input ready);
    modport sink   (input valid, input sum_bits, input range_error, output ready);
endinterface

FILE: design/dfa_core.sv
// Combinational add, align and normalize datapath for one operand pair
module dfa_core (
    input  logic [dfa_pkg::WordWidth-1:0] i_a,
    input  logic [dfa_pkg::WordWidth-1:0] i_b,
    output dfa_pkg::t_result              o_res
);
    localparam int W = dfa_pkg::WordWidth;
    logic [10:0] a_exp, b_exp, big, diff;
    logic        a_zero, b_zero, a_gt;
    logic [W-1:0] ma, mb, sa, sb;
    logic [W:0]  total, mag;
    logic        neg;
    logic [6:0]  n;
    logic [W-1:0] norm;
    logic signed [12:0] e;

    always_comb begin
        a_exp  = i_a[62:52];
        b_exp  = i_b[62:52];
        a_zero = (i_a[62:0] == '0);
        b_zero = (i_b[62:0] == '0);
        a_gt   = a_exp > b_exp;
        big    = a_gt ? a_exp : b_exp;
        diff   = a_gt ? (a_exp - b_exp) : (b_exp - a_exp);
        ma = {11'd0, 1'b1, i_a[51:0]};
        mb = {11'd0, 1'b1, i_b[51:0]};
        // truncating alignment of the smaller operand
        sa = a_gt ? ma : ((diff >= 11'd64) ? '0 : (ma >> diff[5:0]));
        sb = !a_gt ? mb : ((diff >= 11'd64) ? '0 : (mb >> diff[5:0]));
        total = (i_a[63] ? -{1'b0, sa} : {1'b0, sa})
              + (i_b[63] ? -{1'b0, sb} : {1'b0, sb});
        neg = total[W];
        mag = neg ? -total : total;
        // leading-one position: magnitude is at most 54 bits
        n = '0;
        for (int i = 0; i < 55; i++) begin
            if (mag[i]) n = 7'(i + 1);
        end
        if (n < 7'(dfa_pkg::MantWidth)) begin
            norm = mag[W-1:0] << (7'(dfa_pkg::MantWidth) - n);
        end else begin
            norm = mag[W-1:0] >> (n - 7'(dfa_pkg::MantWidth));
        end
        e = $signed({2'b0, big}) + $signed({6'b0, n}) - 13'sd53;
        if (a_zero) begin
            o_res = '{sum_bits: i_b, range_error: 1'b0};
        end else if (b_zero) begin
            o_res = '{sum_bits: i_a, range_error: 1'b0};
        end else if (mag == '0) begin
            o_res = '{sum_bits: '0, range_error: 1'b0};
        end else begin
            o_res.sum_bits    = {neg, e[10:0], norm[51:0]};
            o_res.range_error = (e < 13'sd1) || (e > $signed({2'b0, dfa_pkg::ExpMax}));
        end
    end
endmodule

FILE: design/double_float_adder_truncating_unit.sv
// Truncating binary64 adder: input register, datapath, output register.
// Items pass the input, then the result register; one is taken per cycle
// unless the sink stalls, the single-pass datapath between them setting that
// rate. A result waiting on a stalled sink still lets one more item enter the
// input stage. No rounding, subnormal, infinity or NaN handling.
`include "double_float_adder_truncating_unit_macros.svh"
module double_float_adder_truncating_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dfa_in_if.sink       i_in,
    dfa_out_if.source    o_out
);
    logic r_in_v, r_out_v, n_in_v, n_out_v;
    logic [dfa_pkg::WordWidth-1:0] r_a, r_b;
    dfa_pkg::t_result res, r_res;
    logic adv;

    dfa_core u_core (.i_a(r_a), .i_b(r_b), .o_res(res));

    // stage moves when output is free or being taken
    assign adv = !r_out_v || o_out.ready;
    assign i_in.ready = !r_in_v || adv;
    assign n_in_v  = i_in.valid || (r_in_v && !adv);
    assign n_out_v = r_in_v || (r_out_v && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_in.ready) r_in_v <= n_in_v;
            if (adv) r_out_v <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_a <= i_in.operand_a;
            r_b <= i_in.operand_b;
        end
        if (adv && r_in_v) r_res <= res;
    end

    assign o_out.valid       = r_out_v;
    assign o_out.sum_bits    = r_res.sum_bits;
    assign o_out.range_error = r_res.range_error;

    `DFA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_v && !o_out.ready, r_out_v)
    `DFA_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, r_in_v && r_out_v && !o_out.ready, !i_in.ready)
    `DFA_ASSERT_NEXT(a_fill, i_clk, i_rst_n, r_in_v && adv, r_out_v)
endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the truncating binary64 adder
`timescale 1ns / 100ps

// Holds the predicted sums in arrival order and compares each result with them
class sum_scoreboard;
    typedef struct {
        logic [63:0] sum_bits;
        logic        range_error;
    } t_sum;

    t_sum pending[$];
    int   errors;
    int   checked;

    // Predict the truncated sum of two binary64 patterns
    function t_sum add_truncate(logic [63:0] a, logic [63:0] b);
        t_sum r;
        logic [10:0]        ea, eb;
        logic [51:0]        fa, fb;
        int                 big, n;
        logic signed [64:0] ma, mb, tot;
        logic [63:0]        mag;
        r.range_error = 1'b0;
        ea = a[62:52];
        eb = b[62:52];
        fa = a[51:0];
        fb = b[51:0];
        if (ea == 0 && fa == 0) begin
            r.sum_bits = b;
            return r;
        end
        if (eb == 0 && fb == 0) begin
            r.sum_bits = a;
            return r;
        end
        big = (ea > eb) ? ea : eb;
        ma = (big - ea >= 64) ? 65'sd0 : $signed({12'd0, 1'b1, fa} >> (big - ea));
        mb = (big - eb >= 64) ? 65'sd0 : $signed({12'd0, 1'b1, fb} >> (big - eb));
        if (a[63]) ma = -ma;
        if (b[63]) mb = -mb;
        tot = ma + mb;
        if (tot == 0) begin
            r.sum_bits = 64'd0;
            return r;
        end
        mag = (tot < 0) ? 64'(-tot) : 64'(tot);
        n = 0;
        for (int i = 0; i < 64; i++)
            if (mag[i]) n = i + 1;
        if (n < 53) begin
            mag = mag << (53 - n);
            big = big - (53 - n);
        end else if (n > 53) begin
            mag = mag >> (n - 53);
            big = big + (n - 53);
        end
        r.sum_bits = {tot < 0, 11'(big), mag[51:0]};
        r.range_error = (big < 1 || big > 2046);
        return r;
    endfunction

    function void note_operands(logic [63:0] a, logic [63:0] b);
        pending.push_back(add_truncate(a, b));
    endfunction

    task check_sum(logic [63:0] sum, logic rerr);
        t_sum e;
        checked++;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", sum));
            return;
        end
        e = pending.pop_front();
        if (sum !== e.sum_bits)
            report_mismatch($sformatf("sum_bits %h, predicted %h", sum, e.sum_bits));
        if (rerr !== e.range_error)
            report_mismatch($sformatf("range_error %b, predicted %b", rerr, e.range_error));
    endtask

    task report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask
endclass

module testbench;
    logic i_clk;
    logic i_rst_n;

    dfa_in_if  in_ch();
    dfa_out_if out_ch();

    double_float_adder_truncating_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sum_scoreboard sb;
    int  sent;
    bit  long_hold;
    bit  stim_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Build a random operand: half with close exponents, some special patterns
    function logic [63:0] rand_operand();
        logic [63:0] v;
        int sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v[62:52] = 11'(1023 + $urandom_range(0, 8) - 4);
        else if (sel == 6)
            v[62:0] = 63'd0;
        else if (sel == 7)
            v[62:52] = ($urandom_range(0, 1)) ? 11'd0 : 11'd2047;
        return v;
    endfunction

    // Offer one item and wait until it is taken
    task automatic send_item(logic [63:0] a, logic [63:0] b);
        in_ch.valid     <= 1'b1;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_operands(a, b);
        sent++;
    endtask

    task automatic idle_input(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Stimulus
    initial begin
        logic [63:0] one, d[$];
        int burst;
        sb = new();
        sent = 0;
        long_hold = 0;
        stim_done = 0;
        in_ch.valid     <= 1'b0;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zeros, cancellation, big shifts, range wrap, odd encodings
        one = 64'h3FF0_0000_0000_0000;
        d = '{64'h0, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000, one,
              one, {1'b1, one[62:0]}, one, 64'h0010_0000_0000_0000,
              64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
              64'h0010_0000_0000_0000, 64'h8010_0000_0000_0001,
              64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001,
              64'h7FF0_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
              64'h4340_0000_0000_0000, 64'hBFF0_0000_0000_0000,
              64'h3FF8_0000_0000_0000, 64'h3FF8_0000_0000_0000,
              64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
              one, 64'h7FE0_0000_0000_0000};
        for (int i = 0; i + 1 < d.size(); i += 2) send_item(d[i], d[i+1]);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
        send_item(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);

        // Sender pauses until every result is back
        wait_drained();

        // Receiver holds off while items keep coming
        long_hold = 1;
        fork
            begin
                repeat (30) send_item(rand_operand(), rand_operand());
            end
            begin
                repeat (60) @(posedge i_clk);
                long_hold = 0;
            end
        join

        // Random bursts with random gaps
        while (sent < 430) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                logic [63:0] a;
                a = rand_operand();
                if ($urandom_range(0, 7) == 0)
                    send_item(a, {~a[63], a[62:0]});
                else
                    send_item(a, rand_operand());
            end
            if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        stim_done = 1;
    end

    // Receiver stall pattern and result checking
    initial begin
        int phase;
        phase = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_sum(out_ch.sum_bits, out_ch.range_error);
            phase++;
            if (long_hold)
                out_ch.ready <= 1'b0;
            else if ((phase / 50) % 3 == 0)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // End of run
    initial begin
        wait (stim_done);
        $display("Sent %0d operand pairs, checked %0d sums, incl. zero, cancel, range cases.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
